[rtl/core/blstk_pkg.sv]
// Shared types, codes and constants of the bounded LIFO stack.
`default_nettype none

package blstk_pkg;

	// Built depth and word width.
	localparam int DEPTH_DEFAULT = 16;
	localparam int WORD_W = 32;
	localparam int CAP_W = 5;
	localparam int INDEX_W = 5;

	// Capacity register value after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Word returned on a failed pop or peek.
	localparam logic [WORD_W-1:0] ERR_WORD = 32'hFFFF_FFFF;

	// Operation codes.
	localparam logic [1:0] FUNC_PUSH = 2'd0;
	localparam logic [1:0] FUNC_POP = 2'd1;
	localparam logic [1:0] FUNC_PEEK = 2'd2;

	// Status codes.
	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_BADIDX = 2'd3;

	// Control that every cell of the chain sees in the same cycle.
	typedef struct packed {
		logic push;
		logic pop;
		logic load_rd;
		logic shift_rd;
	} cell_ctl_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_PEEK = 2'b10
	} state_t;

endpackage

`default_nettype wire

[rtl/core/bounded_lifo_stack_top.sv]
// Top level of the bounded LIFO stack: command sequencer, count and result registers.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high and
//   busy low; func selects push, pop or peek, value is the pushed word and index
//   the peek position counted from the top (1 is the top).
//   Result channel: done is high for exactly one cycle while data, status,
//   is_empty and is_full hold the result; the receiver cannot stall it.
//   Configuration channel: cfg_ready is always high; a transaction with cfg_valid
//   writes the capacity. Write it only while no command is in progress.
// Timing:
//   Push, pop, a failed peek and the unused code give their result in the cycle
//   after the command and the next command may follow at once (one per cycle).
//   A valid peek of position i gives its result once the entries, copied into
//   the cells' read registers, have been shifted one cell per cycle toward the
//   top until entry i reaches cell 0. busy is high meanwhile and drops as done
//   rises, so the next command is taken at the edge that ends the result cycle.
// Reset:
//   arst_n clears the count, the capacity to its reset value and the sequencer.
//   Entries hold nothing defined until pushed.
`default_nettype none

module bounded_lifo_stack_top #(
	parameter int DEPTH = blstk_pkg::DEPTH_DEFAULT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [1:0]                         func,
	input  wire logic signed [blstk_pkg::WORD_W-1:0] value,
	input  wire logic [blstk_pkg::INDEX_W-1:0]      index,
	output logic                                    done,
	output logic signed [blstk_pkg::WORD_W-1:0]     data,
	output logic [1:0]                              status,
	output logic                                    is_empty,
	output logic                                    is_full,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [blstk_pkg::CAP_W-1:0]        cfg_data
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > blstk_pkg::CAP_W) ? CW : blstk_pkg::CAP_W;

	blstk_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] remain_q, remain_d;
	logic [blstk_pkg::CAP_W-1:0] cap_q;
	blstk_pkg::cell_ctl_t ctl;

	logic [blstk_pkg::WORD_W-1:0] top_entry;
	logic [blstk_pkg::WORD_W-1:0] top_rd;

	logic [CMPW-1:0] cap_nz;
	logic [CMPW-1:0] cap_live;
	logic [CMPW-1:0] count_ext;
	logic [CMPW-1:0] count_d_ext;
	logic [CMPW-1:0] index_ext;

	logic res_valid;
	logic [blstk_pkg::WORD_W-1:0] res_data;
	logic [1:0] res_status;

	logic done_q;
	logic [blstk_pkg::WORD_W-1:0] data_q;
	logic [1:0] status_q;
	logic is_empty_q;
	logic is_full_q;

	// Capacity register; the channel is always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= blstk_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// Capacity in force: zero acts as one, anything above the built depth as the depth.
	always_comb begin
		cap_nz = (cap_q == '0) ? CMPW'(1) : CMPW'(cap_q);
		cap_live = (cap_nz > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_nz;
	end

	assign count_ext = CMPW'(count_q);
	assign count_d_ext = CMPW'(count_d);
	assign index_ext = CMPW'(index);
	assign busy = (state_q != blstk_pkg::ST_IDLE);

	// Command decode and peek sequencing.
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		remain_d = remain_q;
		ctl = '0;
		res_valid = 1'b0;
		res_data = '0;
		res_status = blstk_pkg::STAT_OK;

		case (state_q)
			blstk_pkg::ST_IDLE: begin
				if (start) begin
					res_valid = 1'b1;
					case (func)
						blstk_pkg::FUNC_PUSH: begin
							if (count_ext >= cap_live) begin
								res_status = blstk_pkg::STAT_FULL;
							end else begin
								ctl.push = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
						blstk_pkg::FUNC_POP: begin
							if (count_q == '0) begin
								res_status = blstk_pkg::STAT_EMPTY;
								res_data = blstk_pkg::ERR_WORD;
							end else begin
								ctl.pop = 1'b1;
								count_d = count_q - CW'(1);
								res_data = top_entry;
							end
						end
						blstk_pkg::FUNC_PEEK: begin
							if (index == '0 || index_ext > count_ext) begin
								res_status = blstk_pkg::STAT_BADIDX;
								res_data = blstk_pkg::ERR_WORD;
							end else begin
								res_valid = 1'b0;
								ctl.load_rd = 1'b1;
								remain_d = CW'(index_ext - CMPW'(1));
								state_d = blstk_pkg::ST_PEEK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			blstk_pkg::ST_PEEK: begin
				if (remain_q == '0) begin
					res_valid = 1'b1;
					res_data = top_rd;
					state_d = blstk_pkg::ST_IDLE;
				end else begin
					ctl.shift_rd = 1'b1;
					remain_d = remain_q - CW'(1);
				end
			end
			default: begin
				state_d = blstk_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blstk_pkg::ST_IDLE;
			count_q <= '0;
			remain_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			remain_q <= remain_d;
			done_q <= res_valid;
		end
	end

	// Result registers; the flags reflect the count after the step.
	always_ff @(posedge clk) begin
		if (res_valid) begin
			data_q <= res_data;
			status_q <= res_status;
			is_empty_q <= (count_d == '0);
			is_full_q <= (count_d_ext >= cap_live);
		end
	end

	blstk_chain #(
		.DEPTH (DEPTH)
	) u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.push_word (value),
		.top_entry (top_entry),
		.top_rd    (top_rd)
	);

	assign done = done_q;
	assign data = data_q;
	assign status = status_q;
	assign is_empty = is_empty_q;
	assign is_full = is_full_q;

endmodule

`default_nettype wire

[rtl/core/blstk_cell.sv]
// One stack cell: an entry register and a read register that shifts toward the top.
`default_nettype none

module blstk_cell (
	input  wire logic                            clk,
	input  wire blstk_pkg::cell_ctl_t            ctl,
	input  wire logic [blstk_pkg::WORD_W-1:0]    above_entry,
	input  wire logic [blstk_pkg::WORD_W-1:0]    below_entry,
	input  wire logic [blstk_pkg::WORD_W-1:0]    below_rd,
	output logic      [blstk_pkg::WORD_W-1:0]    entry_q,
	output logic      [blstk_pkg::WORD_W-1:0]    rd_q
);

	// A push moves every entry one place down, a pop one place up.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= above_entry;
		end else if (ctl.pop) begin
			entry_q <= below_entry;
		end
	end

	// The read register takes a copy of the entry, then passes it up one cell per cycle.
	always_ff @(posedge clk) begin
		if (ctl.load_rd) begin
			rd_q <= entry_q;
		end else if (ctl.shift_rd) begin
			rd_q <= below_rd;
		end
	end

endmodule

`default_nettype wire

[rtl/core/blstk_chain.sv]
// Row of stack cells with the top entry in cell 0.
`default_nettype none

module blstk_chain #(
	parameter int DEPTH = blstk_pkg::DEPTH_DEFAULT
) (
	input  wire logic                            clk,
	input  wire blstk_pkg::cell_ctl_t            ctl,
	input  wire logic [blstk_pkg::WORD_W-1:0]    push_word,
	output logic      [blstk_pkg::WORD_W-1:0]    top_entry,
	output logic      [blstk_pkg::WORD_W-1:0]    top_rd
);

	logic [blstk_pkg::WORD_W-1:0] entry [DEPTH];
	logic [blstk_pkg::WORD_W-1:0] rd [DEPTH];

	// Each cell is wired to its neighbors; the ends see the push word or their own value.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [blstk_pkg::WORD_W-1:0] above_w;
		logic [blstk_pkg::WORD_W-1:0] below_w;
		logic [blstk_pkg::WORD_W-1:0] below_rd_w;

		if (k == 0) begin : g_first
			assign above_w = push_word;
		end else begin : g_mid_a
			assign above_w = entry[k-1];
		end

		if (k == DEPTH - 1) begin : g_last
			assign below_w = entry[k];
			assign below_rd_w = rd[k];
		end else begin : g_mid_b
			assign below_w = entry[k+1];
			assign below_rd_w = rd[k+1];
		end

		blstk_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.above_entry (above_w),
			.below_entry (below_w),
			.below_rd    (below_rd_w),
			.entry_q     (entry[k]),
			.rd_q        (rd[k])
		);
	end

	assign top_entry = entry[0];
	assign top_rd = rd[0];

endmodule

`default_nettype wire

[verif/bounded_lifo_stack_top_test.sv]
// Self-checking testbench of the bounded LIFO stack: a directed table, then randomized phases.
`default_nettype none

module bounded_lifo_stack_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import blstk_pkg::*;

	localparam int DEPTH = DEPTH_DEFAULT;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// Long enough for a valid peek of the deepest entry, with margin.
	localparam int SETTLE_CYCLES = DEPTH + 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic signed [WORD_W-1:0] data;
		logic [1:0] status;
		logic is_empty;
		logic is_full;
	} stack_result_t;

	typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

	typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX} burst_t;

	typedef struct {
		row_kind_t kind;
		logic [1:0] op;
		logic signed [WORD_W-1:0] word;
		logic [INDEX_W-1:0] pos;
		logic [CAP_W-1:0] cap;
		bit typed;
		stack_result_t want;
	} stim_row_t;

	// Ports of the block.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] func = FUNC_PUSH;
	logic signed [WORD_W-1:0] value = '0;
	logic [INDEX_W-1:0] index = '0;
	logic done;
	logic signed [WORD_W-1:0] data;
	logic [1:0] status;
	logic is_empty;
	logic is_full;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CAP_W-1:0] cfg_data = CAP_RESET;

	// Mirror of the stack contents and the capacity register.
	logic signed [WORD_W-1:0] held_words [DEPTH];
	int held_count = 0;
	logic [CAP_W-1:0] cap_reg = CAP_RESET;

	stack_result_t expected_results [$];
	stim_row_t directed_rows [$];

	int mismatch_count = 0;
	int checked_count = 0;
	int cycle_count = 0;
	bit idle_enabled = 1'b1;

	int n_push_ok = 0;
	int n_push_full = 0;
	int n_pop_ok = 0;
	int n_pop_empty = 0;
	int n_peek_ok = 0;
	int n_peek_bad = 0;
	int n_unused = 0;
	int n_cfg = 0;

	bounded_lifo_stack_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.value(value),
		.index(index),
		.done(done),
		.data(data),
		.status(status),
		.is_empty(is_empty),
		.is_full(is_full),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Clock: 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d results still outstanding",
				cycle_count, expected_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Computes the result of one command and advances the mirrored stack.
	function automatic stack_result_t predict_stack_result(input logic [1:0] op,
			input logic signed [WORD_W-1:0] word, input logic [INDEX_W-1:0] pos);
		stack_result_t r;
		int cap;
		cap = (cap_reg == 0) ? 1 : ((int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg));
		r.data = '0;
		r.status = STAT_OK;
		case (op)
			FUNC_PUSH: begin
				if (held_count >= cap) begin
					r.status = STAT_FULL;
				end else begin
					held_words[held_count] = word;
					held_count++;
				end
			end
			FUNC_POP: begin
				if (held_count == 0) begin
					r.status = STAT_EMPTY;
					r.data = ERR_WORD;
				end else begin
					held_count--;
					r.data = held_words[held_count];
				end
			end
			FUNC_PEEK: begin
				if (pos == 0 || int'(pos) > held_count) begin
					r.status = STAT_BADIDX;
					r.data = ERR_WORD;
				end else begin
					r.data = held_words[held_count - int'(pos)];
				end
			end
			default: begin
			end
		endcase
		r.is_empty = (held_count == 0);
		r.is_full = (held_count >= cap);
		return r;
	endfunction

	function automatic stim_row_t row_cmd(input logic [1:0] op, input logic signed [WORD_W-1:0] word,
			input logic [INDEX_W-1:0] pos);
		stim_row_t row;
		row.kind = ROW_CMD;
		row.op = op;
		row.word = word;
		row.pos = pos;
		row.cap = '0;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	// Command row whose result is written out by hand.
	function automatic stim_row_t row_chk(input logic [1:0] op, input logic signed [WORD_W-1:0] word,
			input logic [INDEX_W-1:0] pos, input logic signed [WORD_W-1:0] want_data,
			input logic [1:0] want_status, input logic want_empty, input logic want_full);
		stim_row_t row;
		row = row_cmd(op, word, pos);
		row.typed = 1'b1;
		row.want.data = want_data;
		row.want.status = want_status;
		row.want.is_empty = want_empty;
		row.want.is_full = want_full;
		return row;
	endfunction

	function automatic stim_row_t row_cfg(input logic [CAP_W-1:0] cap);
		stim_row_t row;
		row = row_cmd(FUNC_PUSH, '0, '0);
		row.kind = ROW_CFG;
		row.cap = cap;
		return row;
	endfunction

	// Presents one command, holds it until the block takes it, then maybe idles.
	task automatic issue_cmd(input logic [1:0] op, input logic signed [WORD_W-1:0] word,
			input logic [INDEX_W-1:0] pos, input bit typed, input stack_result_t want);
		stack_result_t guess;
		start <= 1'b1;
		func <= op;
		value <= word;
		index <= pos;
		do @(posedge clk); while (busy);
		guess = predict_stack_result(op, word, pos);
		expected_results.push_back(typed ? want : guess);
		case (op)
			FUNC_PUSH: if (guess.status == STAT_OK) n_push_ok++; else n_push_full++;
			FUNC_POP: if (guess.status == STAT_OK) n_pop_ok++; else n_pop_empty++;
			FUNC_PEEK: if (guess.status == STAT_OK) n_peek_ok++; else n_peek_bad++;
			default: n_unused++;
		endcase
		// Each cycle idles with a chance of 38 in a hundred.
		while (idle_enabled && $urandom_range(99) < 38) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Waits for every outstanding result, then lets the block settle.
	task automatic wait_drained();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the capacity register once the block is idle.
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		start <= 1'b0;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_reg = cap;
		n_cfg++;
	endtask

	// Each result transaction is compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		stack_result_t got;
		stack_result_t want;
		if (arst_n && done) begin
			got.data = data;
			got.status = status;
			got.is_empty = is_empty;
			got.is_full = is_full;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result with no command outstanding: data %0d status %0d",
						$time, $signed(got.data), got.status);
			end else begin
				want = expected_results.pop_front();
				checked_count++;
				if (got.data !== want.data || got.status !== want.status ||
						got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("%0t: result %0d: expected data %0d status %0d empty %0b full %0b,",
							$time, checked_count, $signed(want.data), want.status,
							want.is_empty, want.is_full);
						$display("    got data %0d status %0d empty %0b full %0b",
							$signed(got.data), got.status, got.is_empty, got.is_full);
					end
				end
			end
		end
	end

	// Stimulus.
	initial begin : stimulus
		logic [CAP_W-1:0] cap_plan [NUM_PHASES];
		logic signed [WORD_W-1:0] extremes [4];
		burst_t burst_mode;
		int burst_left;
		int roll;
		logic [1:0] op;
		logic signed [WORD_W-1:0] word;
		logic [INDEX_W-1:0] pos;

		cap_plan = '{5'd16, 5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd17, 5'd2, 5'd16, 5'd9, 5'd3, 5'd16};
		extremes = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF};

		// Directed table: empty stack, word extremes, peek bounds, capacity corner values.
		directed_rows.push_back(row_chk(FUNC_POP, 32'sd0, 5'd0, ERR_WORD, STAT_EMPTY, 1'b1, 1'b0));
		directed_rows.push_back(row_chk(FUNC_PEEK, 32'sd0, 5'd0, ERR_WORD, STAT_BADIDX, 1'b1, 1'b0));
		directed_rows.push_back(row_chk(FUNC_UNUSED, 32'shFFFF_FFFF, 5'd31, 32'sd0, STAT_OK,
			1'b1, 1'b0));
		directed_rows.push_back(row_chk(FUNC_PUSH, 32'sh7FFF_FFFF, 5'd0, 32'sd0, STAT_OK, 1'b0, 1'b0));
		directed_rows.push_back(row_chk(FUNC_PUSH, 32'sh8000_0000, 5'd31, 32'sd0, STAT_OK, 1'b0, 1'b0));
		directed_rows.push_back(row_chk(FUNC_PUSH, 32'shFFFF_FFFF, 5'd0, 32'sd0, STAT_OK, 1'b0, 1'b0));
		directed_rows.push_back(row_cmd(FUNC_PEEK, 32'sd0, 5'd1));
		directed_rows.push_back(row_cmd(FUNC_PEEK, 32'sd0, 5'd3));
		directed_rows.push_back(row_cmd(FUNC_PEEK, 32'sd0, 5'd2));
		directed_rows.push_back(row_chk(FUNC_PEEK, 32'sd0, 5'd4, ERR_WORD, STAT_BADIDX, 1'b0, 1'b0));
		directed_rows.push_back(row_chk(FUNC_PEEK, 32'sd0, 5'd31, ERR_WORD, STAT_BADIDX, 1'b0, 1'b0));
		directed_rows.push_back(row_cmd(FUNC_POP, 32'sd0, 5'd0));
		directed_rows.push_back(row_cfg(5'd2));
		directed_rows.push_back(row_chk(FUNC_PUSH, 32'sd5, 5'd0, 32'sd0, STAT_FULL, 1'b0, 1'b1));
		directed_rows.push_back(row_cmd(FUNC_PEEK, 32'sd0, 5'd2));
		// Capacity zero behaves as one; the stack now holds more than that.
		directed_rows.push_back(row_cfg(5'd0));
		directed_rows.push_back(row_chk(FUNC_PUSH, 32'sd7, 5'd0, 32'sd0, STAT_FULL, 1'b0, 1'b1));
		directed_rows.push_back(row_cmd(FUNC_POP, 32'sd0, 5'd0));
		directed_rows.push_back(row_cmd(FUNC_POP, 32'sd0, 5'd0));
		directed_rows.push_back(row_chk(FUNC_POP, 32'sd0, 5'd0, ERR_WORD, STAT_EMPTY, 1'b1, 1'b0));
		directed_rows.push_back(row_chk(FUNC_PUSH, 32'sh1234_5678, 5'd0, 32'sd0, STAT_OK, 1'b0, 1'b1));
		// Capacity above the built depth behaves as the depth.
		directed_rows.push_back(row_cfg(5'd31));
		directed_rows.push_back(row_chk(FUNC_PUSH, 32'sd0, 5'd16, 32'sd0, STAT_OK, 1'b0, 1'b0));
		directed_rows.push_back(row_cmd(FUNC_PEEK, 32'sd0, 5'd2));
		directed_rows.push_back(row_cmd(FUNC_POP, 32'sd0, 5'd0));

		// Hold reset, then release it.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_capacity(directed_rows[i].cap);
			else
				issue_cmd(directed_rows[i].op, directed_rows[i].word, directed_rows[i].pos,
					directed_rows[i].typed, directed_rows[i].want);
		end

		// Random phases, each under its own capacity; one phase runs without idle cycles.
		burst_mode = BURST_MIX;
		burst_left = 0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_capacity((p == 9) ? CAP_W'($urandom_range(0, 31)) : cap_plan[p]);
			idle_enabled = (p != 2);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Bursts that mostly fill or mostly drain reach both ends of the stack.
				if (burst_left == 0) begin
					burst_mode = burst_t'($urandom_range(0, 2));
					burst_left = $urandom_range(4, 24);
				end
				burst_left--;
				roll = $urandom_range(99);
				case (burst_mode)
					BURST_FILL: op = (roll < 70) ? FUNC_PUSH : (roll < 80) ? FUNC_POP :
						(roll < 98) ? FUNC_PEEK : FUNC_UNUSED;
					BURST_DRAIN: op = (roll < 10) ? FUNC_PUSH : (roll < 70) ? FUNC_POP :
						(roll < 98) ? FUNC_PEEK : FUNC_UNUSED;
					default: op = (roll < 35) ? FUNC_PUSH : (roll < 65) ? FUNC_POP :
						(roll < 97) ? FUNC_PEEK : FUNC_UNUSED;
				endcase
				roll = $urandom_range(99);
				if (roll < 15)
					word = extremes[$urandom_range(0, 3)];
				else
					word = $urandom;
				// Peek positions mostly land on held entries, sometimes just outside.
				roll = $urandom_range(99);
				if (roll < 80)
					pos = INDEX_W'($urandom_range(1, (held_count > 0) ? held_count : 1));
				else if (roll < 90)
					pos = (roll < 85) ? INDEX_W'(held_count + 1) : '0;
				else
					pos = INDEX_W'($urandom_range(0, 31));
				issue_cmd(op, word, pos, 1'b0, '0);
			end
		end

		start <= 1'b0;
		wait_drained();

		$display("covered %0d pushes (%0d refused as full), %0d pops (%0d on empty),",
			n_push_ok + n_push_full, n_push_full, n_pop_ok + n_pop_empty, n_pop_empty);
		$display("%0d peeks (%0d bad index), %0d unused codes, %0d capacity writes",
			n_peek_ok + n_peek_bad, n_peek_bad, n_unused, n_cfg);
		$display("%0d results checked, %0d mismatches, %0d cycles",
			checked_count, mismatch_count, cycle_count);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
rtl/core/blstk_pkg.sv
rtl/core/blstk_cell.sv
rtl/core/blstk_chain.sv
rtl/core/bounded_lifo_stack_top.sv
verif/bounded_lifo_stack_top_test.sv
